// ----- rtl/core/tga_rle_pixel_decoder_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define TGARLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TGARLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tgarle_pkg.sv -----
package tgarle_pkg;

  localparam int unsigned PixelW          = 32;
  localparam int unsigned CountW          = 8;
  localparam int unsigned TotalW          = 32;
  localparam int unsigned PixelsPerResult = 2;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COMPRESSED = 2'd0,
    CFG_FOUR_BYTE  = 2'd1,
    CFG_TOTAL      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              compressed_mode;
    logic              four_byte_pixels;
    logic [TotalW-1:0] total_pixels;
  } cfg_t;

  // One decoded pixel repeated cnt times; last_pix marks the final image pixel.
  typedef struct packed {
    logic [PixelW-1:0] px;
    logic [CountW-1:0] cnt;
    logic              last_pix;
  } job_t;

endpackage

// ----- rtl/core/tgarle_fifo.sv -----
module tgarle_fifo #(
  parameter int unsigned Width = 41,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/core/tgarle_front.sv -----
module tgarle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgarle_pkg::cfg_t  cfg_i,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  output logic              job_valid_o,
  output tgarle_pkg::job_t  job_o
);
  import tgarle_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_RAW    = 2'd2
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] remain_q, remain_d;
  logic [1:0]        pos_q, pos_d;
  logic [PixelW-1:0] asm_q, asm_d;
  logic [TotalW-1:0] done_q, done_d;

  logic [1:0]        last_pos;
  logic [PixelW-1:0] asm_new;
  logic              complete;
  logic              finished;
  logic [CountW-1:0] n_raw, n_clip;
  logic [TotalW-1:0] left;
  logic              clip;

  assign last_pos = cfg_i.four_byte_pixels ? 2'd3 : 2'd2;
  assign asm_new  = asm_q | ({24'b0, data_byte_i} << {pos_q, 3'b000});
  assign complete = (pos_q >= last_pos);
  assign finished = (done_q >= cfg_i.total_pixels);
  assign left     = cfg_i.total_pixels - done_q;

  always_comb begin
    phase_d  = phase_q;
    remain_d = remain_q;
    pos_d    = pos_q;
    asm_d    = asm_q;
    n_raw    = '0;
    if (accept_i && !finished) begin
      // byte gathering, shared by every pixel-data path
      if (!cfg_i.compressed_mode || phase_q == PH_RUN || phase_q == PH_RAW) begin
        if (complete) begin
          pos_d = '0;
          asm_d = '0;
        end else begin
          pos_d = pos_q + 2'd1;
          asm_d = asm_new;
        end
      end
      if (!cfg_i.compressed_mode) begin
        n_raw = complete ? CountW'(1) : '0;
      end else begin
        case (phase_q)
          PH_RUN: begin
            if (complete) begin
              n_raw    = remain_q;
              remain_d = '0;
              phase_d  = PH_HEADER;
            end
          end
          PH_RAW: begin
            if (complete) begin
              n_raw = CountW'(1);
              if (remain_q <= CountW'(1)) begin
                remain_d = '0;
                phase_d  = PH_HEADER;
              end else begin
                remain_d = remain_q - CountW'(1);
              end
            end
          end
          default: begin
            // packet header; a stray phase code also lands here
            if (data_byte_i[7]) begin
              phase_d  = PH_RUN;
              remain_d = data_byte_i - 8'd127;
            end else begin
              phase_d  = PH_RAW;
              remain_d = data_byte_i + 8'd1;
            end
            pos_d = '0;
            asm_d = '0;
          end
        endcase
      end
    end
  end

  // clip against the pixels still owed to the image
  assign clip        = ({{(TotalW-CountW){1'b0}}, n_raw} >= left);
  assign n_clip      = clip ? left[CountW-1:0] : n_raw;
  assign job_valid_o = (n_clip != '0);
  assign done_d      = !job_valid_o ? done_q :
                       clip ? cfg_i.total_pixels : done_q + TotalW'(n_clip);

  assign job_o.px       = asm_new;
  assign job_o.cnt      = n_clip;
  assign job_o.last_pix = clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      remain_q <= '0;
      pos_q    <= '0;
      asm_q    <= '0;
      done_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      asm_q    <= asm_d;
      done_q   <= done_d;
    end
  end

endmodule

// ----- rtl/core/tgarle_back.sv -----
module tgarle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  tgarle_pkg::job_t  job_i,
  output logic              job_take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [31:0]       pixel_first_o,
  output logic [31:0]       pixel_second_o,
  output logic [1:0]        pair_count_o,
  output logic              image_done_o,
  output logic              last_of_item_o
);
  import tgarle_pkg::*;

  localparam logic [CountW-1:0] Ppr = CountW'(PixelsPerResult);

  logic              valid_q, valid_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [PixelW-1:0] px_q;
  logic              last_pix_q;
  logic              full_pair, final_res, retire;

  assign full_pair  = (rem_q >= Ppr);
  assign final_res  = (rem_q <= Ppr);
  assign retire     = valid_q && pop_i && final_res;
  assign job_take_o = job_valid_i && (!valid_q || retire);

  assign empty_o        = !valid_q;
  assign pixel_first_o  = px_q;
  assign pixel_second_o = full_pair ? px_q : '0;
  assign pair_count_o   = full_pair ? 2'(PixelsPerResult) : 2'd1;
  assign last_of_item_o = final_res;
  assign image_done_o   = final_res && last_pix_q;

  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    if (job_take_o) begin
      valid_d = 1'b1;
      rem_d   = job_i.cnt;
    end else if (retire) begin
      valid_d = 1'b0;
    end else if (valid_q && pop_i) begin
      rem_d = rem_q - Ppr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      px_q       <= job_i.px;
      last_pix_q <= job_i.last_pix;
    end
  end

endmodule

// ----- rtl/core/tga_rle_pixel_decoder_core.sv -----
// Targa RLE pixel decoder: push the image's pixel-data bytes (after the header)
// one per transaction; pop results carrying up to two copies of a decoded pixel
// (first stream byte in bits 7:0, bits 31:24 zero for 24-bit pixels).
// In compressed mode a header byte >= 128 starts a run of (header - 127) copies
// of the next pixel, a header < 128 starts (header + 1) literal pixels; in raw
// mode bytes are gathered straight into pixels. Output stops at total_pixels;
// the result holding the final pixel has image_done set, and later bytes are
// swallowed without results. last_of_item marks the last result of a byte.
// Rate: one byte per cycle while the job queue has room. A byte that completes
// a pixel queues one job; the back end drains a job of n pixels as ceil(n/2)
// results at one per popped cycle, so a long run (up to 128 pixels, 64
// results) backs up the QUEUE_DEPTH-entry queue and then holds full high.
// Config (cfg_idx_i 0: compressed_mode, 1: four_byte_pixels, 2: total_pixels)
// is for the user to write only while idle (not enforced); index 3 is ignored.
// No clearing pass after reset: the block is ready on the first cycle.
module tga_rle_pixel_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] pixel_first_o,
  output logic [31:0] pixel_second_o,
  output logic [1:0]  pair_count_o,
  output logic        image_done_o,
  output logic        last_of_item_o
);
  import tgarle_pkg::*;

  cfg_t cfg_q;
  logic accept;
  logic job_valid;
  job_t job_in, job_out;
  logic q_full, q_empty, q_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compressed_mode  <= 1'b1;
      cfg_q.four_byte_pixels <= 1'b0;
      cfg_q.total_pixels     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COMPRESSED: cfg_q.compressed_mode  <= cfg_data_i[0];
        CFG_FOUR_BYTE:  cfg_q.four_byte_pixels <= cfg_data_i[0];
        CFG_TOTAL:      cfg_q.total_pixels     <= cfg_data_i[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // full stays high until the queue can take a job, whatever the byte is
  assign full   = q_full;
  assign accept = push && !q_full;

  // front end: packet parsing, pixel assembly, pixel budget
  tgarle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // decoupling queue of pixel jobs
  tgarle_fifo #(
    .Width ($bits(job_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_in),
    .full_o  (q_full),
    .pop_i   (q_take),
    .rdata_o (job_out),
    .empty_o (q_empty)
  );

  // back end: expands a job into pixel-pair results
  tgarle_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!q_empty),
    .job_i          (job_out),
    .job_take_o     (q_take),
    .empty_o        (empty),
    .pop_i          (pop),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .pair_count_o   (pair_count_o),
    .image_done_o   (image_done_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

// ----- rtl/core/tgarle_checker.sv -----
`include "tga_rle_pixel_decoder_core_macros.svh"

module tgarle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] pixel_first_o,
  input logic [31:0] pixel_second_o,
  input logic [1:0]  pair_count_o,
  input logic        image_done_o,
  input logic        last_of_item_o
);

  logic [67:0] res_w;
  logic        stall;
  logic        count_ok;
  logic        pair_ok;
  logic        done_ok;

  // whole result transaction, for the hold check
  assign res_w    = {pixel_first_o, pixel_second_o, pair_count_o, image_done_o,
                     last_of_item_o};
  assign stall    = !empty && !pop;
  assign count_ok = (pair_count_o == 2'd1) || (pair_count_o == 2'd2);
  assign pair_ok  = (pair_count_o == 2'd2 && pixel_second_o == pixel_first_o) ||
                    (pair_count_o == 2'd1 && pixel_second_o == 32'd0);
  assign done_ok  = !image_done_o || last_of_item_o;

  `TGARLE_ASSERT(a_hold, clk_i, rst_ni, stall |=> !empty && $stable(res_w), "result changed")
  `TGARLE_ASSERT(a_count, clk_i, rst_ni, !empty |-> count_ok, "pair_count out of range")
  `TGARLE_ASSERT(a_pair, clk_i, rst_ni, !empty |-> pair_ok, "second pixel mismatch")
  `TGARLE_ASSERT(a_done, clk_i, rst_ni, !empty |-> done_ok, "image_done off last result")
  // a reset edge leaves nothing to pop on the next one
  `TGARLE_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |=> empty, "output during reset")

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .pixel_first_o  (pixel_first_o),
  .pixel_second_o (pixel_second_o),
  .pair_count_o   (pair_count_o),
  .image_done_o   (image_done_o),
  .last_of_item_o (last_of_item_o)
);

// ----- test/tga_rle_pixel_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_core_tb;
  import tgarle_pkg::*;

  localparam int unsigned RUN_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYC  = 20;
  localparam logic [31:0] TOTAL_MAX   = 32'd4294836225;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_RAW    = 2'd2
  } dec_phase_e;

  // One popped transaction: up to two copies of a decoded pixel.
  typedef struct {
    logic [31:0] px_a;
    logic [31:0] px_b;
    logic [1:0]  n_px;
    logic        img_done;
    logic        item_end;
  } pixel_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] pixel_first_o;
  logic [31:0] pixel_second_o;
  logic [1:0]  pair_count_o;
  logic        image_done_o;
  logic        last_of_item_o;

  tga_rle_pixel_decoder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_first_o  (pixel_first_o),
    .pixel_second_o (pixel_second_o),
    .pair_count_o   (pair_count_o),
    .image_done_o   (image_done_o),
    .last_of_item_o (last_of_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the register file, reset values.
  logic        cfg_compressed = 1'b1;
  logic        cfg_four       = 1'b0;
  logic [31:0] cfg_total      = '0;

  // Mirror of the decode state.
  dec_phase_e  dec_phase = PH_HEADER;
  logic [7:0]  pkt_left  = '0;
  logic [1:0]  byte_pos  = '0;
  logic [31:0] px_acc    = '0;
  logic [31:0] px_done   = '0;

  logic [7:0]  byte_stream_q [$];   // bytes waiting to be pushed
  pixel_pair_t pixel_pair_q [$];    // pixel pairs the decoder still owes us

  int          tx_wait = 0;
  int          rx_wait = 0;
  int          rx_hold = 0;         // long pop hold-off, in cycles
  bit          tx_steady = 1'b0;    // no sender gaps this phase
  bit          rx_steady = 1'b0;    // no receiver gaps this phase
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic int draw_wait(bit steady);
    if (steady || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Appends a byte to the pixel being assembled; returns 1 with the pixel when complete.
  // A pixel completes once the byte slot reaches the current size minus one or more,
  // so dropping from 4 to 3 bytes with two or more bytes gathered finishes on the next byte.
  function automatic logic take_byte(logic [7:0] b, output logic [31:0] px);
    logic [1:0] top;
    top    = cfg_four ? 2'd3 : 2'd2;
    px_acc = px_acc | (32'(b) << (8 * byte_pos));
    px     = '0;
    if (byte_pos >= top) begin
      px       = px_acc;
      px_acc   = '0;
      byte_pos = '0;
      return 1'b1;
    end
    byte_pos = byte_pos + 2'd1;
    return 1'b0;
  endfunction

  // Decodes one accepted byte and queues the pixel pairs it must produce.
  function automatic void decode_byte(logic [7:0] b);
    logic [31:0] px;
    logic [31:0] n;
    logic [31:0] left;
    logic [31:0] nres;
    logic [31:0] r;
    pixel_pair_t pp;
    n = '0;
    // image already complete (also covers a total of zero): byte swallowed
    if (px_done >= cfg_total) return;
    if (!cfg_compressed) begin
      // raw mode leaves packet state alone
      if (take_byte(b, px)) n = 1;
    end else begin
      case (dec_phase)
        PH_RUN: begin
          if (take_byte(b, px)) begin
            n         = 32'(pkt_left);
            pkt_left  = '0;
            dec_phase = PH_HEADER;
          end
        end
        PH_RAW: begin
          if (take_byte(b, px)) begin
            n = 1;
            if (pkt_left <= 8'd1) begin
              pkt_left  = '0;
              dec_phase = PH_HEADER;
            end else begin
              pkt_left = pkt_left - 8'd1;
            end
          end
        end
        default: begin
          // packet header; drops any partly gathered pixel
          if (b >= 8'd128) begin
            dec_phase = PH_RUN;
            pkt_left  = b - 8'd127;
          end else begin
            dec_phase = PH_RAW;
            pkt_left  = b + 8'd1;
          end
          byte_pos = '0;
          px_acc   = '0;
        end
      endcase
    end
    // clip packets that would run past the end of the image
    left = cfg_total - px_done;
    if (n > left) n = left;
    if (n == 0) return;
    px_done = px_done + n;
    nres    = (n + 1) / 2;
    for (r = 0; r < nres; r++) begin
      pp.n_px     = (n - 2 * r >= 2) ? 2'd2 : 2'd1;
      pp.px_a     = px;
      pp.px_b     = (pp.n_px == 2'd2) ? px : '0;
      pp.item_end = (r + 1 == nres);
      pp.img_done = pp.item_end && (px_done == cfg_total);
      pixel_pair_q.push_back(pp);
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_cnt < 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    mismatch_cnt++;
  endfunction

  // Sender: one byte per push transaction, random gaps between bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      data_byte_i <= '0;
      tx_wait = 0;
    end else begin
      if (push && !full) decode_byte(data_byte_i);
      // load the next byte only when the current one went through or none is offered
      if (!push || !full) begin
        if (tx_wait > 0) begin
          tx_wait--;
          push <= 1'b0;
        end else if (byte_stream_q.size() > 0) begin
          push        <= 1'b1;
          data_byte_i <= byte_stream_q.pop_front();
          tx_wait = draw_wait(tx_steady);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pops with random stalls, checks each transaction against the oldest pair owed.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_pair_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        if (pixel_pair_q.size() == 0) begin
          flag_mismatch("unexpected result, pixel_first", '0, pixel_first_o);
        end else begin
          want = pixel_pair_q.pop_front();
          if (pixel_first_o !== want.px_a)
            flag_mismatch("pixel_first", want.px_a, pixel_first_o);
          if (pixel_second_o !== want.px_b)
            flag_mismatch("pixel_second", want.px_b, pixel_second_o);
          if (pair_count_o !== want.n_px)
            flag_mismatch("pair_count", 32'(want.n_px), 32'(pair_count_o));
          if (image_done_o !== want.img_done)
            flag_mismatch("image_done", 32'(want.img_done), 32'(image_done_o));
          if (last_of_item_o !== want.item_end)
            flag_mismatch("last_of_item", 32'(want.item_end), 32'(last_of_item_o));
        end
        rx_wait = draw_wait(rx_steady);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Register write; only called while the decoder is idle.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_COMPRESSED: cfg_compressed = val[0];
      CFG_FOUR_BYTE:  cfg_four       = val[0];
      CFG_TOTAL:      cfg_total      = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every byte is sent and every owed pair has been popped, then lets the tail settle.
  task automatic drain_block();
    do @(negedge clk_i);
    while (byte_stream_q.size() != 0 || push || pixel_pair_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Mostly well-formed packets with random content, some noise and cut-short packets.
  task automatic queue_packets(int n);
    int         cnt;
    int         len;
    int         k;
    logic [7:0] hdr;
    cnt = 0;
    while (cnt < n) begin
      if (!cfg_compressed || $urandom_range(0, 9) == 0) begin
        byte_stream_q.push_back(8'($urandom));
        cnt++;
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          // run packet, long runs now and then
          hdr = 8'(128 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, 7)));
          len = cfg_four ? 4 : 3;
        end else begin
          hdr = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, 5));
          len = (int'(hdr) + 1) * (cfg_four ? 4 : 3);
        end
        if ($urandom_range(0, 9) == 0) len = len - 1;
        byte_stream_q.push_back(hdr);
        cnt++;
        for (k = 0; k < len && cnt < n + 8; k++) begin
          byte_stream_q.push_back(8'($urandom));
          cnt++;
        end
      end
    end
  endtask

  initial begin
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // total_pixels is zero out of reset: the byte must be swallowed
    byte_stream_q = {8'hFF};
    drain_block();

    // compressed, 24-bit: run of 2, raw of 1, run of 128 clipped at the image end,
    // then a byte past the end that must be dropped
    write_reg(CFG_TOTAL, 32'd10);
    byte_stream_q = {8'h81, 8'h00, 8'hFF, 8'h7F,
                     8'h00, 8'hAA, 8'hBB, 8'hCC,
                     8'hFF, 8'h11, 8'h22, 8'h33,
                     8'h05};
    drain_block();

    // raw mode, 32-bit: one full pixel, then three bytes of the next
    write_reg(CFG_COMPRESSED, 32'd0);
    write_reg(CFG_FOUR_BYTE, 32'd1);
    write_reg(CFG_TOTAL, 32'd13);
    byte_stream_q = {8'hFF, 8'h00, 8'h80, 8'h01, 8'h12, 8'h34, 8'h56};
    drain_block();

    // pixel size drops to 3 with 3 bytes already gathered: next byte closes a 4-byte pixel
    write_reg(CFG_FOUR_BYTE, 32'd0);
    byte_stream_q = {8'h78, 8'h9A, 8'hBC, 8'hDE};
    drain_block();

    // total lowered below pixels done: ignored
    write_reg(CFG_TOTAL, 32'd0);
    byte_stream_q = {8'h80};
    drain_block();

    // random phases; phase 3 streams raw pixels into an open-ended image so every
    // few bytes queue a job and the block is sure to fill up
    for (ph = 0; ph < 8; ph++) begin
      tx_steady = (ph == 3);
      rx_steady = (ph == 5);
      write_reg(CFG_COMPRESSED, (ph == 2 || ph == 3 || ph == 6) ? 32'd0 : 32'd1);
      write_reg(CFG_FOUR_BYTE, 32'($urandom_range(0, 1)));
      write_reg(CFG_TOTAL, (ph == 3 || ph == 4) ? TOTAL_MAX
                                                : px_done + 32'($urandom_range(20, 300)));
      // receiver goes quiet while the sender streams, so the job queue backs up
      if (ph == 3) rx_hold = 400;
      queue_packets((ph == 3) ? 36 : 8);
      drain_block();
    end

    if (mismatch_cnt == 0 && pixel_pair_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
